@@ sv/dpow_pkg.sv @@
// ----------------------------------------------------------------------------
// dpow_pkg
// shared widths, constants and types for the double integer power block
// ----------------------------------------------------------------------------
package dpow_pkg;

  localparam int EXP_W = 32;                 // signed exponent input width
  localparam int MAG_W = EXP_W + 1;          // magnitude, one bit wider
  localparam int IDX_W = $clog2(MAG_W);      // bit index into the magnitude

  localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

  typedef struct packed {
    logic start;   // one-cycle request
    logic recip;   // 1: one over b, 0: a times b
  } fpu_req_t;

endpackage

@@ sv/dpow_fpu.sv @@
// ----------------------------------------------------------------------------
// dpow_fpu
// multi-cycle double multiply and reciprocal, round to nearest even
// ----------------------------------------------------------------------------
module dpow_fpu import dpow_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fpu_req_t    req,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_MUL    = 3'd1;
  localparam logic [2:0] F_PRE    = 3'd2;
  localparam logic [2:0] F_DIV    = 3'd3;
  localparam logic [2:0] F_NORM   = 3'd4;
  localparam logic [2:0] F_DENORM = 3'd5;
  localparam logic [2:0] F_ROUND  = 3'd6;

  logic [2:0]         state;
  logic [105:0]       acc;
  logic signed [12:0] er;
  logic signed [12:0] eb;
  logic               sgn;
  logic [5:0]         cnt;
  logic [52:0]        ma;
  logic [52:0]        mb;
  logic [53:0]        rem;
  logic [55:0]        q;

  // operand decode
  logic [10:0] ea_f, eb_f;
  logic [51:0] fa_f, fb_f;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        sx;

  assign ea_f   = a[62:52];
  assign eb_f   = b[62:52];
  assign fa_f   = a[51:0];
  assign fb_f   = b[51:0];
  assign a_nan  = (ea_f == 11'h7FF) && (fa_f != '0);
  assign b_nan  = (eb_f == 11'h7FF) && (fb_f != '0);
  assign a_inf  = (ea_f == 11'h7FF) && (fa_f == '0);
  assign b_inf  = (eb_f == 11'h7FF) && (fb_f == '0);
  assign a_zero = (ea_f == '0) && (fa_f == '0);
  assign b_zero = (eb_f == '0) && (fb_f == '0);
  assign sx     = a[63] ^ b[63];

  logic signed [12:0] ea_u, eb_u;
  assign ea_u = (ea_f == '0) ? 13'sd1 : $signed({2'b00, ea_f});
  assign eb_u = (eb_f == '0) ? 13'sd1 : $signed({2'b00, eb_f});

  // partial product of the 53x53 significand multiply, 27x27 per cycle
  logic [26:0]  ax, bx;
  logic [53:0]  pp;
  logic [105:0] pp_sh;
  always_comb begin
    ax = cnt[0] ? {1'b0, ma[52:27]} : ma[26:0];
    bx = cnt[1] ? {1'b0, mb[52:27]} : mb[26:0];
    pp = ax * bx;
    case (cnt[1:0])
      2'd0:    pp_sh = {52'b0, pp};
      2'd1:    pp_sh = {25'b0, pp, 27'b0};
      2'd2:    pp_sh = {25'b0, pp, 27'b0};
      default: pp_sh = {pp[51:0], 54'b0};
    endcase
  end

  // rounding
  logic [52:0]        rm;
  logic               rinc;
  logic [53:0]        rsum;
  logic signed [12:0] e_out;
  logic [51:0]        f_out;
  always_comb begin
    rm   = acc[105:53];
    rinc = acc[52] & ((|acc[51:0]) | rm[0]);
    rsum = {1'b0, rm} + {53'b0, rinc};
    if (rsum[53]) begin
      e_out = er + 13'sd1;
      f_out = '0;
    end else begin
      e_out = rsum[52] ? er : 13'sd0;
      f_out = rsum[51:0];
    end
  end

  logic [53:0] rem_sub;
  logic        rem_ge;
  assign rem_ge  = rem >= {1'b0, mb};
  assign rem_sub = rem - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        F_IDLE: begin
          if (req.start) begin
            if (!req.recip) begin
              sgn <= sx;
              ma  <= {(ea_f != '0), fa_f};
              mb  <= {(eb_f != '0), fb_f};
              er  <= ea_u + eb_u - 13'sd1022;
              acc <= '0;
              cnt <= '0;
              if (a_nan) begin
                res <= a | QUIET_BIT;
                done <= 1'b1;
              end else if (b_nan) begin
                res <= b | QUIET_BIT;
                done <= 1'b1;
              end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                res <= DEFAULT_NAN;
                done <= 1'b1;
              end else if (a_inf || b_inf) begin
                res <= {sx, 11'h7FF, 52'b0};
                done <= 1'b1;
              end else if (a_zero || b_zero) begin
                res <= {sx, 63'b0};
                done <= 1'b1;
              end else begin
                state <= F_MUL;
              end
            end else begin
              sgn <= b[63];
              mb  <= {(eb_f != '0), fb_f};
              eb  <= eb_u;
              cnt <= '0;
              if (b_nan) begin
                res <= b | QUIET_BIT;
                done <= 1'b1;
              end else if (b_inf) begin
                res <= {b[63], 63'b0};
                done <= 1'b1;
              end else if (b_zero) begin
                res <= {b[63], 11'h7FF, 52'b0};
                done <= 1'b1;
              end else begin
                state <= F_PRE;
              end
            end
          end
        end
        F_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 6'd1;
          if (cnt[1:0] == 2'd3) begin
            state <= F_NORM;
          end
        end
        F_PRE: begin
          // bring a subnormal divisor to a leading one
          if (mb[52]) begin
            rem   <= {2'b01, 52'b0};
            q     <= '0;
            er    <= 13'sd2046 - eb;
            state <= F_DIV;
          end else begin
            mb <= {mb[51:0], 1'b0};
            eb <= eb - 13'sd1;
          end
        end
        F_DIV: begin
          q   <= {q[54:0], rem_ge};
          rem <= rem_ge ? {rem_sub[52:0], 1'b0} : {rem[52:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd55) begin
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (state == F_NORM && cnt == 6'd56) begin
            // quotient bits done, the remainder becomes the sticky bit
            acc <= {q, (rem != '0), 49'b0};
            cnt <= '0;
          end else if (acc == '0) begin
            res   <= {sgn, 63'b0};
            done  <= 1'b1;
            state <= F_IDLE;
          end else if (er < 13'sd1) begin
            state <= F_DENORM;
          end else if (acc[105] || er == 13'sd1) begin
            state <= F_ROUND;
          end else begin
            acc <= {acc[104:0], 1'b0};
            er  <= er - 13'sd1;
          end
        end
        F_DENORM: begin
          if (er == 13'sd1) begin
            state <= F_ROUND;
          end else if (er < -13'sd110) begin
            acc <= {105'b0, |acc};
            er  <= 13'sd1;
          end else begin
            acc <= {1'b0, acc[105:2], acc[1] | acc[0]};
            er  <= er + 13'sd1;
          end
        end
        F_ROUND: begin
          if (e_out >= 13'sd2047) begin
            res <= {sgn, 11'h7FF, 52'b0};
          end else begin
            res <= {sgn, e_out[10:0], f_out};
          end
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/double_power_by_squaring.sv @@
// ----------------------------------------------------------------------------
// double_power_by_squaring
// double base raised to a signed integer power by binary exponentiation
// ----------------------------------------------------------------------------
//  channel  signals                         transfer when
//  in       in_valid in_stall base_bits      in_valid & !in_stall
//           exponent
//  out      out_valid out_stall power_bits   out_valid & !out_stall
//
//  one item at a time through one shared multiply/reciprocal unit
//  multiply: 27x27 partial products, then normalize and round;
//  up to 2 multiplies per exponent bit below the leading one, 60 at most
//  reciprocal: 56 quotient bits; subnormals add shift cycles
//  a zero exponent returns one without the unit; otherwise the time per item is
//  mostly set by the exponent bit count and the number of set bits
//  synchronous reset; a waiting result does not block the next transfer in
module double_power_by_squaring import dpow_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       base_bits,
  input  logic [EXP_W-1:0]  exponent,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       power_bits
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SQW  = 3'd3;
  localparam logic [2:0] S_MBW  = 3'd4;
  localparam logic [2:0] S_RCW  = 3'd5;
  localparam logic [2:0] S_TAIL = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]       state;
  logic [63:0]      base;
  logic [MAG_W-1:0] mag;
  logic             neg;
  logic [IDX_W-1:0] idx;
  logic [63:0]      r;

  fpu_req_t    req;
  logic [63:0] fa, fb;
  logic        fdone;
  logic [63:0] fres;

  dpow_fpu u_fpu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (fa),
    .b    (fb),
    .done (fdone),
    .res  (fres)
  );

  logic [MAG_W-1:0] mag_in;
  assign mag_in = exponent[EXP_W-1] ? (MAG_W'(0) - {exponent[EXP_W-1], exponent})
                                    : {1'b0, exponent};

  assign in_stall = (state != S_IDLE);

  // drive the shared unit
  always_comb begin
    req.start = 1'b0;
    req.recip = 1'b0;
    fa        = r;
    fb        = r;
    case (state)
      S_SQ: begin
        req.start = 1'b1;
      end
      S_SQW: begin
        // square done and the bit is set: chain the multiply by the base
        fb        = base;
        fa        = fres;
        req.start = fdone && mag[idx];
      end
      S_TAIL: begin
        req.start = neg;
        req.recip = 1'b1;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            base <= base_bits;
            mag  <= mag_in;
            neg  <= exponent[EXP_W-1];
            idx  <= IDX_W'(MAG_W - 1);
            if (mag_in == '0) begin
              r     <= ONE_BITS;
              state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (mag[idx]) begin
            r <= base;
            if (idx == '0) begin
              state <= S_TAIL;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= S_SQ;
            end
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_SQ: begin
          state <= S_SQW;
        end
        S_SQW: begin
          if (fdone) begin
            r <= fres;
            if (mag[idx]) begin
              state <= S_MBW;
            end else if (idx == '0) begin
              state <= S_TAIL;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= S_SQ;
            end
          end
        end
        S_MBW: begin
          if (fdone) begin
            r <= fres;
            if (idx == '0) begin
              state <= S_TAIL;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= S_SQ;
            end
          end
        end
        S_TAIL: begin
          state <= neg ? S_RCW : S_OUT;
        end
        S_RCW: begin
          if (fdone) begin
            r     <= fres;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            power_bits <= r;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/dpow_checker.sv @@
// ----------------------------------------------------------------------------
// dpow_checker
// port-level checks on the double integer power block
// ----------------------------------------------------------------------------
module dpow_checker import dpow_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [63:0]       base_bits,
  input logic [EXP_W-1:0]  exponent,
  input logic              out_valid,
  input logic              out_stall,
  input logic [63:0]       power_bits
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // a result cannot appear in the cycle after an input transfer
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result without work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(power_bits))
    else $error("stalled result changed");

endmodule

bind double_power_by_squaring dpow_checker u_dpow_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// checks double_power_by_squaring against known answers and a square-and-multiply
// predictor built on host IEEE doubles; directed table first, then random items under
// several sender/receiver idling phases, a long receiver hold-off and a drain
// ----------------------------------------------------------------------------
module testbench;
  import dpow_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 1000;
  localparam int N_RANDOM    = 400;

  typedef struct {
    logic [63:0]      base;
    logic [EXP_W-1:0] expo;
    logic [63:0]      power;
  } power_exp_t;

  typedef struct {
    logic [63:0]      base;
    logic [EXP_W-1:0] expo;
    bit               typed;   // 1: power column is the known answer
    logic [63:0]      power;
  } power_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [63:0]      base_bits = '0;
  logic [EXP_W-1:0] exponent = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [63:0]      power_bits;

  power_exp_t pending_powers[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  double_power_by_squaring uut (.*);

  always #1 clk = ~clk;

  // square-and-multiply over the exponent magnitude, then reciprocal if negative
  function automatic logic [63:0] predict_power(logic [63:0] b, logic [EXP_W-1:0] e);
    logic [MAG_W-1:0] mag;
    real x, r;
    int top;
    mag = e[EXP_W-1] ? (~{1'b1, e} + 1'b1) : {1'b0, e};
    if (mag == '0) return ONE_BITS;
    x = $bitstoreal(b);
    top = MAG_W - 1;
    while (!mag[top]) top--;
    r = x;
    for (int i = top - 1; i >= 0; i--) begin
      r = r * r;
      if (mag[i]) r = r * x;
    end
    if (e[EXP_W-1]) r = 1.0 / r;
    return $realtobits(r);
  endfunction

  task automatic report(string what);
    errors++;
    if (errors <= 30) $display("[%0t] error: %s", $realtime, what);
  endtask

  task automatic send_power(logic [63:0] b, logic [EXP_W-1:0] e, bit typed,
                            logic [63:0] known);
    power_exp_t x;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    base_bits = b;
    exponent = e;
    do @(posedge clk); while (in_stall);
    x.base = b;
    x.expo = e;
    x.power = typed ? known : predict_power(b, e);
    pending_powers.push_back(x);
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_powers();
    while (pending_powers.size() != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_base();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: r[62:52] = 11'(1019 + $urandom_range(8));
      4:          ;
      5: begin
        case ($urandom_range(5))
          0: r = 64'h7FF0_0000_0000_0000;
          1: r = 64'hFFF0_0000_0000_0000;
          2: r = {r[63], 63'h0};
          3: r = {r[63], 11'h3FF, 52'h0};
          4: r[62:52] = 11'h7FF;
          default: r = {r[63], 11'h400, 52'h0};
        endcase
      end
      6:          r[62:52] = 11'h000;
      7:          r[62:52] = 11'(2046 - $urandom_range(30));
      default:    r[62:52] = 11'($urandom_range(1, 60));
    endcase
    return r;
  endfunction

  function automatic logic [EXP_W-1:0] pick_exponent();
    int k;
    k = $urandom_range(80);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1) ? EXP_W'(k) : EXP_W'(-k);
      6:                return $urandom;
      7:                return $urandom_range(1) ? EXP_W'({1'b0, {(EXP_W-1){1'b1}}} - k)
                                                 : EXP_W'({1'b1, {(EXP_W-1){1'b0}}} + k);
      default:          return EXP_W'($urandom_range(1));
    endcase
  endfunction

  task automatic random_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    repeat (n) send_power(pick_base(), pick_exponent(), 1'b0, '0);
  endtask

  // receiver: random stall, or a long hold-off when the sender asks for one
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // output transfer check
  always @(posedge clk) begin
    power_exp_t x;
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (pending_powers.size() == 0) begin
        report($sformatf("unexpected result %h", power_bits));
      end else begin
        x = pending_powers.pop_front();
        n_checked++;
        if (power_bits !== x.power)
          report($sformatf("base %h exp %0d: power_bits %h, want %h",
                           x.base, $signed(x.expo), power_bits, x.power));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  power_row_t directed[] = '{
    '{64'h4000_0000_0000_0000, 32'd0,          1, ONE_BITS},
    '{64'hFFF8_0000_0000_0000, 32'd0,          1, ONE_BITS},
    '{64'h7FF0_0000_0000_0000, 32'd0,          1, ONE_BITS},
    '{64'h4000_0000_0000_0000, 32'd1,          1, 64'h4000_0000_0000_0000},
    '{64'h4000_0000_0000_0000, -32'sd1,        1, 64'h3FE0_0000_0000_0000},
    '{64'hC000_0000_0000_0000, 32'd3,          1, 64'hC020_0000_0000_0000},
    '{64'h3FF0_0000_0000_0000, 32'h8000_0000, 1, ONE_BITS},
    '{64'hBFF0_0000_0000_0000, 32'h7FFF_FFFF, 1, 64'hBFF0_0000_0000_0000},
    '{64'hBFF0_0000_0000_0000, 32'h8000_0000, 1, ONE_BITS},
    '{64'h7FF0_0000_0000_0000, 32'd2,          1, 64'h7FF0_0000_0000_0000},
    '{64'h0000_0000_0000_0000, -32'sd1,        1, 64'h7FF0_0000_0000_0000},
    '{64'h8000_0000_0000_0000, -32'sd1,        1, 64'hFFF0_0000_0000_0000},
    '{64'h4000_0000_0000_0000, 32'd1024,       1, 64'h7FF0_0000_0000_0000},
    '{64'h4000_0000_0000_0000, -32'sd1074,     1, 64'h0000_0000_0000_0000},
    '{64'h0000_0000_0000_0001, 32'd2,          1, 64'h0000_0000_0000_0000},
    '{64'h4024_0000_0000_0000, 32'h8000_0000, 1, 64'h0000_0000_0000_0000},
    '{64'h3FE0_0000_0000_0000, 32'h8000_0000, 1, 64'h7FF0_0000_0000_0000},
    '{64'h7FEF_FFFF_FFFF_FFFF, 32'd2,          1, 64'h7FF0_0000_0000_0000},
    '{64'h3FF8_0000_0000_0000, 32'h7FFF_FFFF, 0, '0},
    '{64'h3FF0_0000_0000_0001, 32'h7FFF_FFFF, 0, '0},
    '{64'h3FEF_FFFF_FFFF_FFFF, 32'h8000_0001, 0, '0},
    '{64'h7FF4_0000_0000_0001, 32'd5,          0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, -32'sd1,        0, '0},
    '{64'h000F_FFFF_FFFF_FFFF, -32'sd3,        0, '0},
    '{64'h4009_21FB_5444_2D18, 32'd13,         0, '0}
  };

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      send_power(directed[i].base, directed[i].expo, directed[i].typed,
                 directed[i].power);

    random_phase(80, 0, 0);
    random_phase(70, 85, 0);
    random_phase(70, 0, 85);
    random_phase(70, 25, 25);

    // long receiver hold-off while items keep coming, so the input backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (30) send_power(pick_base(), pick_exponent(), 1'b0, '0);
    // pause the sender until every result is back
    drain_powers();
    random_phase(80, 0, 0);

    drain_powers();
    repeat (SETTLE) @(negedge clk);

    $display("sent %0d items (%0d directed), checked %0d results in %0d cycles",
             n_sent, directed.size(), n_checked, cycles);
    $display("phases: free run, sparse sender, stalling receiver, both, long hold-off");
    if (errors == 0 && pending_powers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dpow_pkg.sv
sv/dpow_fpu.sv
sv/double_power_by_squaring.sv
sv/dpow_checker.sv
tb/testbench.sv
